// ===== sv/fgdq_pkg.sv =====
// Shared widths, item kinds and engine handshake types for the distance query core.
package fgdq_pkg;

    localparam int KIND_W   = 2;
    localparam int FIELD_W  = 10;
    localparam int STEPS_W  = 12;
    localparam int COUNT_W  = 11;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic signed [STEPS_W-1:0] STEPS_NONE = -12'sd1;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] node;
        logic [FIELD_W-1:0] target;
    } fgdq_req_t;

    typedef struct packed {
        logic                      valid;
        logic signed [STEPS_W-1:0] steps;
    } fgdq_rsp_t;

endpackage

// ===== sv/fgdq_in_if.sv =====
// Input channel carrying load, build and query words.
interface fgdq_in_if;
    logic                        valid;
    logic                        ready;
    logic [fgdq_pkg::KIND_W-1:0]  kind;
    logic [fgdq_pkg::FIELD_W-1:0] node;
    logic [fgdq_pkg::FIELD_W-1:0] target;

    modport source (output valid, kind, node, target, input ready);
    modport sink   (input valid, kind, node, target, output ready);
endinterface

// ===== sv/fgdq_out_if.sv =====
// Output channel carrying query results.
interface fgdq_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fgdq_pkg::STEPS_W-1:0] steps;

    modport source (output valid, steps, input ready);
    modport sink   (input valid, steps, output ready);
endinterface

// ===== sv/fgdq_engine.sv =====
// Table build and query sequencer with its node memories.
module fgdq_engine #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fgdq_pkg::COUNT_W-1:0]      node_count,
    input  fgdq_pkg::fgdq_req_t               req,
    output logic                              req_ready,
    output fgdq_pkg::fgdq_rsp_t               rsp,
    input  logic                              rsp_ready
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = (NW + 1 > fgdq_pkg::COUNT_W) ? NW + 1 : fgdq_pkg::COUNT_W;
    localparam int KW   = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int KCW  = $clog2(JUMP_LEVELS + 1);
    localparam int JDEPTH = JUMP_LEVELS * (2 ** NW);
    localparam logic [NCW-1:0] MAXN = NCW'(MAX_NODES);
    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SAN_RD, S_SAN_WR, S_LVL_RD1, S_LVL_RD2, S_LVL_WR, S_CLR2,
        S_W_RD, S_W_CHK, S_W_NEXT, S_P_RD, S_P_CHK, S_J_RD, S_J_LD, S_C_RD, S_C_WR,
        S_Q_A, S_Q_B, S_Q_C, S_JMP, S_JMP_LD, S_Q_CMP, S_OUT
    } state_t;

    state_t state_reg;
    logic [NCW-1:0] i_reg, len_reg, t_reg, p_reg, cyc_reg;
    logic [NW-1:0]  x_reg, v_reg, a_reg, b_reg, d_reg, ad_reg, cpb_reg, base_reg, rootv_reg;
    logic [KCW-1:0] k_reg;
    logic           join_reg, ge_reg;
    logic signed [fgdq_pkg::STEPS_W-1:0] steps_reg;

    // memories
    logic [NW-1:0] jt_mem [JDEPTH];
    logic [1:0]    mk_mem [2 ** NW];
    logic [NW-1:0] cp_mem [2 ** NW];
    logic [NW-1:0] dp_mem [2 ** NW];
    logic [NW-1:0] rt_mem [2 ** NW];
    logic [NW-1:0] q_mem  [2 ** NW];

    logic              jt_we;
    logic [KW+NW-1:0]  jt_waddr, jt_raddr;
    logic [NW-1:0]     jt_wdata, jt_q;
    logic              mk_we;
    logic [NW-1:0]     mk_waddr, mk_raddr;
    logic [1:0]        mk_wdata, mk_q;
    logic              cp_we;
    logic [NW-1:0]     cp_waddr, cp_wdata, cp_q;
    logic              nd_we;
    logic [NW-1:0]     nd_waddr, nd_raddr, dp_wdata, rt_wdata, dp_q, rt_q;
    logic              q_we;
    logic [NW-1:0]     q_waddr, q_raddr, q_wdata, q_q;

    logic [NCW-1:0] n_w, nc_ext, node_ext, target_ext, j_w;
    logic [NW-1:0]  d_shift;
    logic [NW:0]    cyc_sum;
    logic           walk_go, is_cyc, d_bit, i_last;

    always_comb
    begin
        nc_ext = NCW'(node_count);
        if (nc_ext == '0)
            n_w = NCW'(1);
        else if (nc_ext > MAXN)
            n_w = MAXN;
        else
            n_w = nc_ext;
    end

    assign node_ext   = NCW'(req.node);
    assign target_ext = NCW'(req.target);
    assign walk_go    = (mk_q == MARK_NONE) && (len_reg < n_w);
    assign is_cyc     = !join_reg && (t_reg >= p_reg);
    assign j_w        = t_reg - p_reg;
    assign d_shift    = d_reg >> k_reg;
    assign d_bit      = d_shift[0];
    assign cyc_sum    = {1'b0, cpb_reg} + {1'b0, ad_reg};
    assign i_last     = (i_reg == n_w - NCW'(1));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.steps = steps_reg;

    always_comb
    begin
        jt_we = 1'b0; jt_waddr = '0; jt_wdata = '0; jt_raddr = '0;
        mk_we = 1'b0; mk_waddr = '0; mk_wdata = MARK_NONE; mk_raddr = x_reg;
        cp_we = 1'b0; cp_waddr = '0; cp_wdata = '0;
        nd_we = 1'b0; nd_waddr = '0; dp_wdata = '0; rt_wdata = '0; nd_raddr = x_reg;
        q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr = t_reg[NW-1:0];
        unique case (state_reg)
            S_CLR, S_CLR2:
            begin
                mk_we = 1'b1; mk_waddr = i_reg[NW-1:0]; mk_wdata = MARK_NONE;
                cp_we = 1'b1; cp_waddr = i_reg[NW-1:0]; cp_wdata = '0;
            end
            S_IDLE:
            begin
                if (req.valid && req.kind == fgdq_pkg::KIND_LOAD && node_ext < MAXN)
                begin
                    jt_we    = 1'b1;
                    jt_waddr = {KW'(0), NW'(req.node)};
                    jt_wdata = NW'(req.target);
                end
            end
            S_SAN_RD: jt_raddr = {KW'(0), i_reg[NW-1:0]};
            S_SAN_WR:
            begin
                if (NCW'(jt_q) >= n_w)
                begin
                    jt_we    = 1'b1;
                    jt_waddr = {KW'(0), i_reg[NW-1:0]};
                    jt_wdata = i_reg[NW-1:0];
                end
            end
            S_LVL_RD1: jt_raddr = {KW'(k_reg - KCW'(1)), i_reg[NW-1:0]};
            S_LVL_RD2: jt_raddr = {KW'(k_reg - KCW'(1)), jt_q};
            S_LVL_WR:
            begin
                jt_we    = 1'b1;
                jt_waddr = {k_reg[KW-1:0], i_reg[NW-1:0]};
                jt_wdata = jt_q;
            end
            S_W_RD: mk_raddr = x_reg;
            S_W_CHK:
            begin
                if (walk_go)
                begin
                    mk_we = 1'b1; mk_waddr = x_reg; mk_wdata = MARK_PATH;
                    q_we  = 1'b1; q_waddr  = len_reg[NW-1:0]; q_wdata = x_reg;
                    jt_raddr = {KW'(0), x_reg};
                end
            end
            S_P_RD: q_raddr = p_reg[NW-1:0];
            S_J_RD: nd_raddr = x_reg;
            S_C_RD: q_raddr = t_reg[NW-1:0];
            S_C_WR:
            begin
                nd_we = 1'b1; nd_waddr = q_q; rt_wdata = rootv_reg;
                mk_we = 1'b1; mk_waddr = q_q; mk_wdata = MARK_DONE;
                if (join_reg)
                    dp_wdata = NW'(NCW'(base_reg) + len_reg - t_reg);
                else if (is_cyc)
                begin
                    cp_we = 1'b1; cp_waddr = q_q; cp_wdata = NW'(j_w);
                    dp_wdata = (j_w == '0) ? '0 : NW'(cyc_reg - j_w);
                end
                else
                    dp_wdata = NW'(p_reg - t_reg);
            end
            S_Q_A: nd_raddr = a_reg;
            S_Q_B: nd_raddr = b_reg;
            S_JMP: jt_raddr = {k_reg[KW-1:0], v_reg};
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        jt_q <= jt_mem[jt_raddr];
        if (jt_we)
            jt_mem[jt_waddr] <= jt_wdata;
        mk_q <= mk_mem[mk_raddr];
        if (mk_we)
            mk_mem[mk_waddr] <= mk_wdata;
        cp_q <= cp_mem[nd_raddr];
        if (cp_we)
            cp_mem[cp_waddr] <= cp_wdata;
        dp_q <= dp_mem[nd_raddr];
        rt_q <= rt_mem[nd_raddr];
        if (nd_we)
        begin
            dp_mem[nd_waddr] <= dp_wdata;
            rt_mem[nd_waddr] <= rt_wdata;
        end
        q_q <= q_mem[q_raddr];
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            i_reg     <= '0;
            len_reg   <= '0;
            t_reg     <= '0;
            p_reg     <= '0;
            join_reg  <= 1'b0;
            ge_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    if (i_reg == MAXN - NCW'(1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        i_reg <= i_reg + NCW'(1);
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        case (req.kind)
                            fgdq_pkg::KIND_BUILD:
                            begin
                                i_reg     <= '0;
                                state_reg <= S_SAN_RD;
                            end
                            fgdq_pkg::KIND_QUERY:
                            begin
                                a_reg <= NW'(req.node);
                                b_reg <= NW'(req.target);
                                if (node_ext >= n_w || target_ext >= n_w)
                                begin
                                    steps_reg <= fgdq_pkg::STEPS_NONE;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_Q_A;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SAN_RD: state_reg <= S_SAN_WR;
                S_SAN_WR:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        k_reg     <= KCW'(1);
                        state_reg <= (JUMP_LEVELS > 1) ? S_LVL_RD1 : S_CLR2;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NCW'(1);
                        state_reg <= S_SAN_RD;
                    end
                end
                S_LVL_RD1: state_reg <= S_LVL_RD2;
                S_LVL_RD2: state_reg <= S_LVL_WR;
                S_LVL_WR:
                begin
                    if (i_last)
                    begin
                        i_reg <= '0;
                        k_reg <= k_reg + KCW'(1);
                        state_reg <= (k_reg == KCW'(JUMP_LEVELS - 1)) ? S_CLR2 : S_LVL_RD1;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NCW'(1);
                        state_reg <= S_LVL_RD1;
                    end
                end
                S_CLR2:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        x_reg     <= '0;
                        len_reg   <= '0;
                        state_reg <= S_W_RD;
                    end
                    else
                        i_reg <= i_reg + NCW'(1);
                end
                S_W_RD: state_reg <= S_W_CHK;
                S_W_CHK:
                begin
                    if (walk_go)
                    begin
                        len_reg   <= len_reg + NCW'(1);
                        state_reg <= S_W_NEXT;
                    end
                    else if (mk_q == MARK_PATH)
                    begin
                        p_reg     <= '0;
                        join_reg  <= 1'b0;
                        rootv_reg <= x_reg;
                        state_reg <= S_P_RD;
                    end
                    else
                    begin
                        join_reg  <= 1'b1;
                        state_reg <= S_J_RD;
                    end
                end
                S_W_NEXT:
                begin
                    x_reg     <= jt_q;
                    state_reg <= S_W_RD;
                end
                S_P_RD:
                begin
                    if (p_reg < len_reg)
                        state_reg <= S_P_CHK;
                    else
                    begin
                        cyc_reg   <= len_reg - p_reg;
                        t_reg     <= '0;
                        state_reg <= S_C_RD;
                    end
                end
                S_P_CHK:
                begin
                    if (q_q == x_reg)
                    begin
                        cyc_reg   <= len_reg - p_reg;
                        t_reg     <= '0;
                        state_reg <= S_C_RD;
                    end
                    else
                    begin
                        p_reg     <= p_reg + NCW'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_J_RD: state_reg <= S_J_LD;
                S_J_LD:
                begin
                    base_reg  <= dp_q;
                    rootv_reg <= rt_q;
                    t_reg     <= '0;
                    state_reg <= S_C_RD;
                end
                S_C_RD:
                begin
                    if (t_reg < len_reg)
                        state_reg <= S_C_WR;
                    else if (i_last)
                        state_reg <= S_IDLE;
                    else
                    begin
                        // advance to the next start node
                        i_reg     <= i_reg + NCW'(1);
                        x_reg     <= NW'(i_reg + NCW'(1));
                        len_reg   <= '0;
                        state_reg <= S_W_RD;
                    end
                end
                S_C_WR:
                begin
                    t_reg     <= t_reg + NCW'(1);
                    state_reg <= S_C_RD;
                end
                S_Q_A: state_reg <= S_Q_B;
                S_Q_B:
                begin
                    ad_reg    <= dp_q;
                    rootv_reg <= rt_q;
                    state_reg <= S_Q_C;
                end
                S_Q_C:
                begin
                    cpb_reg <= cp_q;
                    if (rootv_reg != rt_q)
                    begin
                        steps_reg <= fgdq_pkg::STEPS_NONE;
                        state_reg <= S_OUT;
                    end
                    else if (ad_reg >= dp_q)
                    begin
                        ge_reg    <= 1'b1;
                        d_reg     <= ad_reg - dp_q;
                        v_reg     <= a_reg;
                        k_reg     <= '0;
                        state_reg <= S_JMP;
                    end
                    else
                    begin
                        ge_reg    <= 1'b0;
                        state_reg <= S_Q_CMP;
                    end
                end
                S_JMP:
                begin
                    if (k_reg == KCW'(JUMP_LEVELS))
                        state_reg <= S_Q_CMP;
                    else if (d_bit)
                        state_reg <= S_JMP_LD;
                    else
                        k_reg <= k_reg + KCW'(1);
                end
                S_JMP_LD:
                begin
                    v_reg     <= jt_q;
                    k_reg     <= k_reg + KCW'(1);
                    state_reg <= S_JMP;
                end
                S_Q_CMP:
                begin
                    if (ge_reg && v_reg == b_reg)
                        steps_reg <= fgdq_pkg::STEPS_W'(d_reg);
                    else if (cpb_reg != '0)
                        steps_reg <= fgdq_pkg::STEPS_W'(cyc_sum);
                    else
                        steps_reg <= fgdq_pkg::STEPS_NONE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_range_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req.valid && req.kind == fgdq_pkg::KIND_QUERY
         && node_ext >= n_w)
        |=> (state_reg == S_OUT && steps_reg == fgdq_pkg::STEPS_NONE))
        else $error("out-of-range query did not answer -1");

    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && i_reg != MAXN - NCW'(1)) |=> (state_reg == S_CLR))
        else $error("reset clearing pass ended early");

    a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W_CHK) |-> (len_reg <= n_w))
        else $error("walk longer than node count");

    a_cycle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_WR && !join_reg) |-> (p_reg < len_reg))
        else $error("cycle start not found on walk path");

endmodule

// ===== sv/functional_graph_distance_query_core.sv =====
// Top level: register port, input channel and result register around the engine.
// A load word is written into the jump table from idle. A query reads the depths and roots of
// both nodes and, if the first is no shallower, walks the jump levels, jumping on each set bit
// of the depth difference, before the result register loads; a range miss answers straight
// from idle, a root miss after the root compare. A build sanitises successors, fills the jump
// levels, then walks the n nodes in use. After reset a clearing pass over MAX_NODES entries holds ready low.
module functional_graph_distance_query_core #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fgdq_in_if.sink                            in_ch,
    fgdq_out_if.source                         out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [fgdq_pkg::PDATA_W-1:0]       pwdata,
    output logic [fgdq_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam logic REG_NODE_COUNT = 1'b0;

    logic [fgdq_pkg::COUNT_W-1:0] nc_reg;
    logic                         out_valid_reg;
    logic signed [fgdq_pkg::STEPS_W-1:0] out_steps_reg;
    fgdq_pkg::fgdq_req_t          req;
    fgdq_pkg::fgdq_rsp_t          rsp;
    logic                         req_ready, rsp_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? fgdq_pkg::PDATA_W'(nc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nc_reg <= fgdq_pkg::COUNT_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT)
            nc_reg <= pwdata[fgdq_pkg::COUNT_W-1:0];
    end

    assign req.valid  = in_ch.valid;
    assign req.kind   = in_ch.kind;
    assign req.node   = in_ch.node;
    assign req.target = in_ch.target;
    assign in_ch.ready = req_ready;

    // hold a result word until taken; refill in the same cycle it drains
    assign rsp_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp.valid;
            if (rsp.valid)
                out_steps_reg <= rsp.steps;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.steps = out_steps_reg;

    fgdq_engine #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (nc_reg),
        .req        (req),
        .req_ready  (req_ready),
        .rsp        (rsp),
        .rsp_ready  (rsp_ready)
    );

endmodule

// ===== sim/tb_functional_graph_distance_query_core.sv =====
// Testbench for the functional-graph distance query core: random graphs, builds and queries.
module tb_functional_graph_distance_query_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_MAX   = 1024;
    localparam int LEVELS      = 10;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_STALL  = 3000;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
    localparam logic [fgdq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [fgdq_pkg::KIND_W-1:0]  kind;
        logic [fgdq_pkg::FIELD_W-1:0] node;
        logic [fgdq_pkg::FIELD_W-1:0] target;
    } graph_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [fgdq_pkg::PDATA_W-1:0] pwdata;
    logic [fgdq_pkg::PDATA_W-1:0] prdata;
    logic pready;

    fgdq_in_if  in_if ();
    fgdq_out_if out_if ();

    functional_graph_distance_query_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the core state
    logic [fgdq_pkg::FIELD_W-1:0] hop_tab [LEVELS][NODES_MAX];
    int unsigned        depth_tab [NODES_MAX];
    int unsigned        root_tab [NODES_MAX];
    int unsigned        ring_pos [NODES_MAX];
    bit [1:0]           seen [NODES_MAX];
    int unsigned        walk_path [NODES_MAX];
    logic [fgdq_pkg::COUNT_W-1:0] node_count_reg;

    graph_word_t                           pending_words [$];
    logic signed [fgdq_pkg::STEPS_W-1:0]   expected_steps [$];

    bit          in_busy;
    bit          calm;
    int unsigned errors;
    int unsigned cycles;
    int unsigned stall_reqs;
    int unsigned stall_done;
    int unsigned stall_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int unsigned active_nodes();
        int unsigned n;
        n = 32'(node_count_reg);
        if (n == 0) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        return n;
    endfunction

    task automatic rebuild_tables();
        int unsigned n;
        int unsigned len;
        int unsigned x;
        int unsigned p;
        int unsigned ring_len;
        int unsigned base;
        int unsigned rt;
        n = active_nodes();
        for (int i = 0; i < n; i++)
            if (hop_tab[0][i] >= n) hop_tab[0][i] = fgdq_pkg::FIELD_W'(i);
        for (int k = 1; k < LEVELS; k++)
            for (int i = 0; i < n; i++)
                hop_tab[k][i] = hop_tab[k-1][hop_tab[k-1][i]];
        for (int i = 0; i < n; i++)
        begin
            seen[i] = 2'd0;
            ring_pos[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (seen[i] != 2'd0) continue;
            len = 0;
            x = i;
            while (seen[x] == 2'd0 && len < n)
            begin
                seen[x] = 2'd1;
                walk_path[len] = x;
                len++;
                x = 32'(hop_tab[0][x]);
            end
            if (seen[x] == 2'd1)
            begin
                // fresh cycle: x becomes the component root
                p = 0;
                while (p < len && walk_path[p] != x) p++;
                ring_len = len - p;
                for (int t = p; t < len; t++)
                begin
                    ring_pos[walk_path[t]] = t - p;
                    depth_tab[walk_path[t]] = (t == p) ? 0 : ring_len - (t - p);
                    root_tab[walk_path[t]] = x;
                end
                for (int t = 0; t < p; t++)
                begin
                    depth_tab[walk_path[t]] = p - t;
                    root_tab[walk_path[t]] = x;
                end
            end
            else
            begin
                base = depth_tab[x];
                rt = root_tab[x];
                for (int t = 0; t < len; t++)
                begin
                    depth_tab[walk_path[t]] = base + (len - t);
                    root_tab[walk_path[t]] = rt;
                end
            end
            for (int t = 0; t < len; t++) seen[walk_path[t]] = 2'd2;
        end
    endtask

    function automatic logic signed [fgdq_pkg::STEPS_W-1:0] distance_of(int unsigned a,
                                                                        int unsigned b);
        int unsigned n;
        int unsigned ad;
        int unsigned bd;
        int unsigned d;
        int unsigned v;
        n = active_nodes();
        if (a >= n || b >= n) return fgdq_pkg::STEPS_NONE;
        if (root_tab[a] != root_tab[b]) return fgdq_pkg::STEPS_NONE;
        ad = depth_tab[a];
        bd = depth_tab[b];
        if (ad >= bd)
        begin
            d = ad - bd;
            v = a;
            for (int k = 0; k < LEVELS; k++)
                if (d[k]) v = 32'(hop_tab[k][v]);
            if (v == b) return d[fgdq_pkg::STEPS_W-1:0];
        end
        if (ring_pos[b] != 0) return fgdq_pkg::STEPS_W'(ring_pos[b] + ad);
        return fgdq_pkg::STEPS_NONE;
    endfunction

    task automatic apply_word(graph_word_t w);
        case (w.kind)
            fgdq_pkg::KIND_LOAD:  hop_tab[0][w.node] = w.target;
            fgdq_pkg::KIND_BUILD: rebuild_tables();
            fgdq_pkg::KIND_QUERY:
                expected_steps = {expected_steps, distance_of(32'(w.node), 32'(w.target))};
            default: ;
        endcase
    endtask

    task automatic push_word(logic [fgdq_pkg::KIND_W-1:0] k, int unsigned a, int unsigned b);
        graph_word_t w;
        w.kind = k;
        w.node = a[fgdq_pkg::FIELD_W-1:0];
        w.target = b[fgdq_pkg::FIELD_W-1:0];
        pending_words = {pending_words, w};
    endtask

    task automatic reg_write(logic [2:0] addr, logic [fgdq_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        node_count_reg = data[fgdq_pkg::COUNT_W-1:0];
    endtask

    // a build gives no result, so hold for its full sweep after the last one
    task automatic wait_drained();
        wait (pending_words.size() == 0 && expected_steps.size() == 0 && !in_busy);
        repeat (64 * active_nodes() + 64) @(posedge clk);
    endtask

    // Input driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_if.valid <= 1'b0;
        else if (!in_busy)
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 36))
            begin
                in_if.valid <= 1'b1;
                in_if.kind <= pending_words[0].kind;
                in_if.node <= pending_words[0].node;
                in_if.target <= pending_words[0].target;
                in_busy = 1'b1;
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // Result ready, with the long hold-off counted here
    always @(negedge clk)
    begin
        if (stall_reqs != stall_done)
        begin
            stall_done = stall_reqs;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= calm || ($urandom_range(99) >= 36);
    end

    // Accept words, check results, watch the clock
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && in_if.valid && in_if.ready)
        begin
            apply_word(pending_words.pop_front());
            in_busy = 1'b0;
        end
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_steps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result steps=%0d", $time, out_if.steps);
            end
            else
            begin
                if (out_if.steps !== expected_steps[0])
                begin
                    errors++;
                    $display("%0t: steps mismatch expected=%0d actual=%0d",
                             $time, expected_steps[0], out_if.steps);
                end
                void'(expected_steps.pop_front());
            end
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned queries;
        int unsigned phase;
        int unsigned qn;
        logic [fgdq_pkg::COUNT_W-1:0] cfg;
        bit chain;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.kind = fgdq_pkg::KIND_LOAD;
        in_if.node = '0;
        in_if.target = '0;
        out_if.ready = 1'b0;
        in_busy = 1'b0;
        calm = 1'b0;
        errors = 0;
        cycles = 0;
        stall_reqs = 0;
        stall_done = 0;
        stall_left = 0;
        node_count_reg = fgdq_pkg::COUNT_RESET;
        for (int k = 0; k < LEVELS; k++)
            for (int i = 0; i < NODES_MAX; i++) hop_tab[k][i] = '0;
        for (int i = 0; i < NODES_MAX; i++)
        begin
            depth_tab[i] = 0;
            root_tab[i] = 0;
            ring_pos[i] = 0;
            seen[i] = 2'd0;
            walk_path[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // hold off the clearing pass after reset
        repeat (NODES_MAX + 50) @(posedge clk);

        // Directed: a ring of nodes 0, 1 and 2 with tails, a self-loop, an out-of-range successor
        reg_write(ADDR_NODE_COUNT, 32'd8);
        push_word(fgdq_pkg::KIND_LOAD, 0, 1);
        push_word(fgdq_pkg::KIND_LOAD, 1, 2);
        push_word(fgdq_pkg::KIND_LOAD, 2, 0);
        push_word(fgdq_pkg::KIND_LOAD, 3, 0);
        push_word(fgdq_pkg::KIND_LOAD, 4, 3);
        push_word(fgdq_pkg::KIND_LOAD, 5, 5);
        push_word(fgdq_pkg::KIND_LOAD, 6, 1023);
        push_word(fgdq_pkg::KIND_LOAD, 7, 4);
        push_word(fgdq_pkg::KIND_BUILD, 0, 0);
        push_word(fgdq_pkg::KIND_QUERY, 7, 0);
        push_word(fgdq_pkg::KIND_QUERY, 7, 2);
        push_word(fgdq_pkg::KIND_QUERY, 4, 1);
        push_word(fgdq_pkg::KIND_QUERY, 0, 2);
        push_word(fgdq_pkg::KIND_QUERY, 2, 1);
        push_word(fgdq_pkg::KIND_QUERY, 0, 4);
        push_word(fgdq_pkg::KIND_QUERY, 5, 5);
        push_word(fgdq_pkg::KIND_QUERY, 6, 6);
        push_word(fgdq_pkg::KIND_QUERY, 0, 5);
        push_word(fgdq_pkg::KIND_QUERY, 0, 9);
        push_word(fgdq_pkg::KIND_QUERY, 1023, 1023);
        push_word(KIND_SPARE, 1023, 1023);
        push_word(fgdq_pkg::KIND_LOAD, 0, 5);
        push_word(fgdq_pkg::KIND_QUERY, 0, 2);
        push_word(fgdq_pkg::KIND_QUERY, 3, 3);
        wait_drained();

        queries = 0;
        phase = 0;
        while (queries < 600 || phase < 8)
        begin
            phase++;
            case (phase)
                1: cfg = 11'd0;
                2: cfg = 11'd1;
                3: cfg = 11'd2047;
                default: cfg = fgdq_pkg::COUNT_W'($urandom_range(2, 48));
            endcase
            reg_write(ADDR_NODE_COUNT, fgdq_pkg::PDATA_W'(cfg));
            n = active_nodes();
            chain = ($urandom_range(3) == 0);
            calm = (phase == 5);
            for (int i = 0; i < n; i++)
            begin
                if (chain && i + 1 < n && $urandom_range(9) != 0)
                    push_word(fgdq_pkg::KIND_LOAD, i, i + 1);
                else if ($urandom_range(9) == 0)
                    push_word(fgdq_pkg::KIND_LOAD, i, $urandom_range(1023));
                else
                    push_word(fgdq_pkg::KIND_LOAD, i, $urandom_range(n - 1));
            end
            push_word(fgdq_pkg::KIND_BUILD, 0, 0);
            qn = (n > 100) ? 40 : $urandom_range(40, 120);
            for (int q = 0; q < qn; q++)
            begin
                case ($urandom_range(19))
                    0: push_word(fgdq_pkg::KIND_QUERY, $urandom_range(1023),
                                 $urandom_range(1023));
                    1: push_word(KIND_SPARE, $urandom_range(1023), $urandom_range(1023));
                    2: push_word(fgdq_pkg::KIND_LOAD, $urandom_range(n - 1),
                                 $urandom_range(1023));
                    3: if (n <= 100) push_word(fgdq_pkg::KIND_BUILD, 0, 0);
                    default: push_word(fgdq_pkg::KIND_QUERY, $urandom_range(n - 1),
                                       $urandom_range(n - 1));
                endcase
                queries++;
            end
            if (phase == 6) stall_reqs++;
            wait_drained();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/fgdq_pkg.sv
sv/fgdq_in_if.sv
sv/fgdq_out_if.sv
sv/fgdq_engine.sv
sv/functional_graph_distance_query_core.sv
sim/tb_functional_graph_distance_query_core.sv
